// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the LED color controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define LHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define LHC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LHC_ASSERT_IMP(lbl, ante, cons)
`define LHC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/lhc_pkg.sv -----
// Shared constants and types of the LED HSV color controller.
`default_nettype none
package lhc_pkg;

  localparam logic [1:0] KIND_POWER  = 2'd0;
  localparam logic [1:0] KIND_HUE    = 2'd1;
  localparam logic [1:0] KIND_SAT    = 2'd2;
  localparam logic [1:0] KIND_BRIGHT = 2'd3;

  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 9;
  localparam int DIV_CNT_W  = 5;

  localparam logic [DIVISOR_W-1:0] SECTOR     = 9'd43;
  localparam logic [8:0]           GREEN_BASE = 9'd85;
  localparam logic [8:0]           BLUE_BASE  = 9'd171;
  localparam logic [DIVISOR_W-1:0] FULL_SCALE = 9'd255;
  localparam logic [DIVISOR_W-1:0] HUE_MAX    = 9'd360;
  localparam logic [DIVISOR_W-1:0] PCT_MAX    = 9'd100;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/led_hsv_color_controller.sv -----
// Top level: command sequencer and color state of the LED HSV color controller.
`default_nettype none
`include "assert_macros.svh"
// Keeps an 8-bit RGB color and applies one power, hue, saturation or brightness
// command per transaction, returning the new drive plus the reported power, hue
// (degrees) and saturation/brightness (percent). Every division runs on the one
// shared serial divider. A power command runs up to five divisions; an HSV
// command runs up to nine divisions. in_stall is high while a command is in
// progress; a finished result waits in the output register until taken.
module led_hsv_color_controller (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [8:0] in_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_power_on,
  output logic [8:0]      out_hue_degrees,
  output logic [6:0]      out_saturation_percent,
  output logic [6:0]      out_brightness_percent
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_HSV     = 14'b00000000000010,
    S_WAIT_S  = 14'b00000000000100,
    S_WAIT_H  = 14'b00000000001000,
    S_NEXT    = 14'b00000000010000,
    S_WAIT_SC = 14'b00000000100000,
    S_WAIT_RG = 14'b00000001000000,
    S_RGB_A   = 14'b00000010000000,
    S_RGB_B   = 14'b00000100000000,
    S_WAIT_OH = 14'b00001000000000,
    S_WAIT_OS = 14'b00010000000000,
    S_WAIT_OV = 14'b00100000000000,
    S_DONE    = 14'b01000000000000,
    S_SPARE   = 14'b10000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       red_r, red_nxt, grn_r, grn_nxt, blu_r, blu_nxt;
  logic [7:0]       h_r, h_nxt, s_r, s_nxt, v_r, v_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [8:0]       value_r, value_nxt;
  logic             post_r, post_nxt;
  logic [2:0]       region_r, region_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       sr1_r, sr1_nxt, sr2_r, sr2_nxt, p_r, p_nxt;
  logic [8:0]       hdeg_r, hdeg_nxt;
  logic [6:0]       spct_r, spct_nxt;
  logic [6:0]       bpct_r, bpct_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       ored_r, ored_nxt, ogrn_r, ogrn_nxt, oblu_r, oblu_nxt;
  logic [8:0]       ohue_r, ohue_nxt;
  logic [6:0]       osat_r, osat_nxt, obri_r, obri_nxt;

  lhc_pkg::div_req_t div_req;
  lhc_pkg::div_rsp_t div_rsp;

  logic [7:0]  hi, lo, span, da, db, mag;
  logic        neg;
  logic [8:0]  base;
  logic [8:0]  hue9;
  logic [8:0]  hue_sat;
  logic [6:0]  pct_sat;
  logic [7:0]  qlo;
  logic [7:0]  comp_new;
  logic [15:0] prod_a, prod_b, prod_c;
  logic [8:0]  sect_off;
  logic        out_free;

  lhc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Max, min and the hue difference of the current color.
  always_comb begin
    hi   = (red_r > grn_r) ? red_r : grn_r;
    hi   = (hi > blu_r) ? hi : blu_r;
    lo   = (red_r < grn_r) ? red_r : grn_r;
    lo   = (lo < blu_r) ? lo : blu_r;
    span = hi - lo;
    if (hi == red_r) begin
      da = grn_r; db = blu_r; base = 9'd0;
    end else if (hi == grn_r) begin
      da = blu_r; db = red_r; base = lhc_pkg::GREEN_BASE;
    end else begin
      da = red_r; db = grn_r; base = lhc_pkg::BLUE_BASE;
    end
    neg = (da < db);
    mag = neg ? (db - da) : (da - db);
  end

  assign qlo      = div_rsp.quotient[7:0];
  assign hue9     = neg ? (base - {1'b0, qlo}) : (base + {1'b0, qlo});
  assign hue_sat  = (value_r > lhc_pkg::HUE_MAX) ? lhc_pkg::HUE_MAX : value_r;
  assign pct_sat  = (value_r > lhc_pkg::PCT_MAX) ? 7'(lhc_pkg::PCT_MAX) : value_r[6:0];
  assign out_free = !ovalid_r || !out_stall;
  assign sect_off = 9'({1'b0, h_r} - 9'(qlo * 8'd43));

  always_comb begin
    state_nxt  = state_r;
    red_nxt    = red_r;
    grn_nxt    = grn_r;
    blu_nxt    = blu_r;
    h_nxt      = h_r;
    s_nxt      = s_r;
    v_nxt      = v_r;
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    post_nxt   = post_r;
    region_nxt = region_r;
    rem_nxt    = rem_r;
    sr1_nxt    = sr1_r;
    sr2_nxt    = sr2_r;
    p_nxt      = p_r;
    hdeg_nxt   = hdeg_r;
    spct_nxt   = spct_r;
    bpct_nxt   = bpct_r;
    ovalid_nxt = ovalid_r && out_stall;
    ored_nxt   = ored_r;
    ogrn_nxt   = ogrn_r;
    oblu_nxt   = oblu_r;
    ohue_nxt   = ohue_r;
    osat_nxt   = osat_r;
    obri_nxt   = obri_r;
    div_req    = '0;
    comp_new   = '0;
    prod_a     = '0;
    prod_b     = '0;
    prod_c     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          value_nxt = in_value;
          if (in_kind == lhc_pkg::KIND_POWER) begin
            post_nxt = 1'b1;
            if (in_value != 9'd0) begin
              if (red_r == 8'd0) red_nxt = 8'hFF;
              if (grn_r == 8'd0) grn_nxt = 8'hFF;
              if (blu_r == 8'd0) blu_nxt = 8'hFF;
            end else begin
              red_nxt = '0;
              grn_nxt = '0;
              blu_nxt = '0;
            end
          end else begin
            post_nxt = 1'b0;
          end
          state_nxt = S_HSV;
        end
      end
      S_HSV: begin
        v_nxt = hi;
        h_nxt = '0;
        s_nxt = '0;
        if (hi == 8'd0) begin
          state_nxt = S_NEXT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 17'({span, 8'd0} - {8'd0, span});
          div_req.divisor  = {1'b0, hi};
          state_nxt        = S_WAIT_S;
        end
      end
      S_WAIT_S: begin
        if (div_rsp.done) begin
          s_nxt = qlo;
          if (qlo == 8'd0 || span == 8'd0) begin
            state_nxt = S_NEXT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 17'(mag * 8'd43);
            div_req.divisor  = {1'b0, span};
            state_nxt        = S_WAIT_H;
          end
        end
      end
      S_WAIT_H: begin
        if (div_rsp.done) begin
          h_nxt     = hue9[7:0];
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        div_req.start = 1'b1;
        if (post_r) begin
          div_req.dividend = 17'(h_r * lhc_pkg::HUE_MAX);
          div_req.divisor  = lhc_pkg::FULL_SCALE;
          state_nxt        = S_WAIT_OH;
        end else if (kind_r == lhc_pkg::KIND_HUE) begin
          div_req.dividend = 17'({hue_sat, 8'd0} - {8'd0, hue_sat});
          div_req.divisor  = lhc_pkg::HUE_MAX;
          state_nxt        = S_WAIT_SC;
        end else begin
          div_req.dividend = 17'({pct_sat, 8'd0} - {8'd0, pct_sat});
          div_req.divisor  = lhc_pkg::PCT_MAX;
          state_nxt        = S_WAIT_SC;
        end
      end
      S_WAIT_SC: begin
        if (div_rsp.done) begin
          comp_new = (kind_r == lhc_pkg::KIND_SAT) ? qlo : s_r;
          case (kind_r)
            lhc_pkg::KIND_HUE: h_nxt = qlo;
            lhc_pkg::KIND_SAT: s_nxt = qlo;
            default:           v_nxt = qlo;
          endcase
          post_nxt = 1'b1;
          if (comp_new == 8'd0) begin
            // Gray: all channels take the value.
            red_nxt   = (kind_r == lhc_pkg::KIND_BRIGHT) ? qlo : v_r;
            grn_nxt   = red_nxt;
            blu_nxt   = red_nxt;
            state_nxt = S_HSV;
          end else begin
            state_nxt = S_RGB_A;
          end
        end
      end
      S_RGB_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = {9'd0, h_r};
        div_req.divisor  = lhc_pkg::SECTOR;
        state_nxt        = S_WAIT_RG;
      end
      S_WAIT_RG: begin
        if (div_rsp.done) begin
          region_nxt = div_rsp.quotient[2:0];
          rem_nxt    = 8'({sect_off[5:0], 2'b00} + {1'b0, sect_off[5:0], 1'b0});
          state_nxt  = S_RGB_B;
        end
      end
      S_RGB_B: begin
        prod_a  = s_r * rem_r;
        prod_b  = s_r * (8'hFF - rem_r);
        prod_c  = v_r * (8'hFF - s_r);
        sr1_nxt = prod_a[15:8];
        sr2_nxt = prod_b[15:8];
        p_nxt   = prod_c[15:8];
        // Final channel products next cycle; reuse the sequencer spare slot.
        state_nxt = S_SPARE;
      end
      S_SPARE: begin
        prod_a = v_r * (8'hFF - sr1_r);
        prod_b = v_r * (8'hFF - sr2_r);
        case (region_r)
          3'd0:    begin red_nxt = v_r;          grn_nxt = prod_b[15:8]; blu_nxt = p_r; end
          3'd1:    begin red_nxt = prod_a[15:8]; grn_nxt = v_r;          blu_nxt = p_r; end
          3'd2:    begin red_nxt = p_r;          grn_nxt = v_r;  blu_nxt = prod_b[15:8]; end
          3'd3:    begin red_nxt = p_r;  grn_nxt = prod_a[15:8];         blu_nxt = v_r; end
          3'd4:    begin red_nxt = prod_b[15:8]; grn_nxt = p_r;          blu_nxt = v_r; end
          default: begin red_nxt = v_r;  grn_nxt = p_r;  blu_nxt = prod_a[15:8]; end
        endcase
        state_nxt = S_HSV;
      end
      S_WAIT_OH: begin
        if (div_rsp.done) begin
          hdeg_nxt         = div_rsp.quotient[8:0];
          div_req.start    = 1'b1;
          div_req.dividend = 17'(s_r * lhc_pkg::PCT_MAX);
          div_req.divisor  = lhc_pkg::FULL_SCALE;
          state_nxt        = S_WAIT_OS;
        end
      end
      S_WAIT_OS: begin
        if (div_rsp.done) begin
          spct_nxt         = div_rsp.quotient[6:0];
          div_req.start    = 1'b1;
          div_req.dividend = 17'(v_r * lhc_pkg::PCT_MAX);
          div_req.divisor  = lhc_pkg::FULL_SCALE;
          state_nxt        = S_WAIT_OV;
        end
      end
      S_WAIT_OV: begin
        if (div_rsp.done) begin
          bpct_nxt  = div_rsp.quotient[6:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ored_nxt   = red_r;
          ogrn_nxt   = grn_r;
          oblu_nxt   = blu_r;
          ohue_nxt   = hdeg_r;
          osat_nxt   = spct_r;
          obri_nxt   = bpct_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      red_r    <= '0;
      grn_r    <= '0;
      blu_r    <= '0;
      post_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      red_r    <= red_nxt;
      grn_r    <= grn_nxt;
      blu_r    <= blu_nxt;
      post_r   <= post_nxt;
      ovalid_r <= ovalid_nxt;
    end
    h_r      <= h_nxt;
    s_r      <= s_nxt;
    v_r      <= v_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    region_r <= region_nxt;
    rem_r    <= rem_nxt;
    sr1_r    <= sr1_nxt;
    sr2_r    <= sr2_nxt;
    p_r      <= p_nxt;
    hdeg_r   <= hdeg_nxt;
    spct_r   <= spct_nxt;
    bpct_r   <= bpct_nxt;
    ored_r   <= ored_nxt;
    ogrn_r   <= ogrn_nxt;
    oblu_r   <= oblu_nxt;
    ohue_r   <= ohue_nxt;
    osat_r   <= osat_nxt;
    obri_r   <= obri_nxt;
  end

  assign in_stall               = (state_r != S_IDLE);
  assign out_valid              = ovalid_r;
  assign out_red                = ored_r;
  assign out_green              = ogrn_r;
  assign out_blue               = oblu_r;
  assign out_power_on           = |{ored_r, ogrn_r, oblu_r};
  assign out_hue_degrees        = ohue_r;
  assign out_saturation_percent = osat_r;
  assign out_brightness_percent = obri_r;

  `LHC_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `LHC_ASSERT_IMP(a_div_idle_wait, div_req.start, state_r != S_IDLE && state_r != S_DONE)
  `LHC_ASSERT_NXT(a_done_loads, state_r == S_DONE && out_free, out_valid && !in_stall)

endmodule
`default_nettype wire

// ----- hw/rtl/lhc_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"
module lhc_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lhc_pkg::div_req_t req,
  output lhc_pkg::div_rsp_t     rsp
);

  logic                                   busy_r, busy_nxt;
  logic                                   done_r, done_nxt;
  logic [lhc_pkg::DIV_CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [lhc_pkg::DIVIDEND_W-1:0]         quo_r, quo_nxt;
  logic [lhc_pkg::DIVISOR_W-1:0]          rem_r, rem_nxt;
  logic [lhc_pkg::DIVISOR_W-1:0]          den_r, den_nxt;
  logic [lhc_pkg::DIVISOR_W:0]            cand;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cand     = {rem_r, quo_r[lhc_pkg::DIVIDEND_W-1]};
    if (busy_r) begin
      if (cand >= {1'b0, den_r}) begin
        rem_nxt = lhc_pkg::DIVISOR_W'(cand - {1'b0, den_r});
        quo_nxt = {quo_r[lhc_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = cand[lhc_pkg::DIVISOR_W-1:0];
        quo_nxt = {quo_r[lhc_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lhc_pkg::DIV_CNT_W'(lhc_pkg::DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `LHC_ASSERT_NXT(a_start_busy, req.start && !busy_r, busy_r)
  `LHC_ASSERT_IMP(a_no_restart, busy_r, !req.start)
  `LHC_ASSERT_IMP(a_done_idle, done_r, !busy_r)

endmodule
`default_nettype wire
